// ----- sv/cicd_pkg.sv -----
// ----------------------------------------------------------------------------
// CIC decimator package
// Shared constants, register index codes and the pipeline control token.
// ----------------------------------------------------------------------------
package cicd_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_STAGES_DEF  = 6;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int ACC_BITS_DEF    = 52;

    // Register and counter widths
    localparam int RATIO_W    = 7;
    localparam int STAGE_W    = 3;
    localparam int SCALE_W    = 33;
    localparam int PHASE_W    = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 33;

    // Register reset values and limits
    localparam logic [RATIO_W-1:0] RATIO_RST  = 7'd10;
    localparam logic [RATIO_W-1:0] RATIO_MAX  = 7'd64;
    localparam logic [STAGE_W-1:0] STAGES_RST = 3'd3;
    localparam logic [SCALE_W-1:0] SCALE_RST  = 33'd4294967;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DECIM_RATIO = 2'd0,
        REG_STAGE_CNT   = 2'd1,
        REG_NORM_SCALE  = 2'd2
    } reg_idx_t;

    // Control that travels with each sample down the cell chain
    typedef struct packed {
        logic emit;   // phase counter was zero: run the combs, give a result
        logic last;   // end of block: clear state once this sample has passed
    } ctl_t;

endpackage

// ----- sv/cicd_if.sv -----
// ----------------------------------------------------------------------------
// CIC decimator channels
// Valid/ready interfaces for samples, results and configuration writes.
// ----------------------------------------------------------------------------
interface cicd_in_if #(
    parameter int SAMPLE_BITS = cicd_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          block_last;

    modport source (output valid, output sample_in, output block_last, input ready);
    modport sink   (input valid, input sample_in, input block_last, output ready);
endinterface

interface cicd_out_if #(
    parameter int SAMPLE_BITS = cicd_pkg::SAMPLE_BITS_DEF,
    parameter int ACC_BITS    = cicd_pkg::ACC_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic signed [ACC_BITS-1:0]    raw_out;

    modport source (output valid, output sample_out, output raw_out, input ready);
    modport sink   (input valid, input sample_out, input raw_out, output ready);
endinterface

interface cicd_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [cicd_pkg::CFG_IDX_W-1:0]      index;
    logic [cicd_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- sv/cicd_integ_cell.sv -----
// ----------------------------------------------------------------------------
// CIC integrator cell
// One wrapping accumulator with its own pipeline register and handshake.
// ----------------------------------------------------------------------------
module cicd_integ_cell #(
    parameter int ACC_BITS = cicd_pkg::ACC_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 used,
    input  logic                 up_valid,
    output logic                 up_ready,
    input  logic [ACC_BITS-1:0]  up_data,
    input  cicd_pkg::ctl_t       up_ctl,
    output logic                 dn_valid,
    input  logic                 dn_ready,
    output logic [ACC_BITS-1:0]  dn_data,
    output cicd_pkg::ctl_t       dn_ctl
);

    logic                valid_reg;
    logic [ACC_BITS-1:0] acc_reg;
    logic [ACC_BITS-1:0] acc_next;
    logic [ACC_BITS-1:0] sum;
    logic [ACC_BITS-1:0] data_reg;
    cicd_pkg::ctl_t      ctl_reg;
    logic                take;

    assign up_ready = !valid_reg || dn_ready;
    assign take     = up_valid && up_ready;
    assign sum      = acc_reg + up_data;

    always_comb
    begin
        if (up_ctl.last)
            acc_next = '0;
        else if (used)
            acc_next = sum;
        else
            acc_next = acc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            acc_reg   <= '0;
        end
        else
        begin
            if (up_ready)
                valid_reg <= up_valid;
            if (take)
                acc_reg <= acc_next;
        end
    end

    // Unused stages pass the sample straight on
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg <= used ? sum : up_data;
            ctl_reg  <= up_ctl;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;
    assign dn_ctl   = ctl_reg;

endmodule

// ----- sv/cicd_comb_cell.sv -----
// ----------------------------------------------------------------------------
// CIC comb cell
// One differentiator with its delay word, active on decimated samples only.
// ----------------------------------------------------------------------------
module cicd_comb_cell #(
    parameter int ACC_BITS = cicd_pkg::ACC_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 used,
    input  logic                 up_valid,
    output logic                 up_ready,
    input  logic [ACC_BITS-1:0]  up_data,
    input  cicd_pkg::ctl_t       up_ctl,
    output logic                 dn_valid,
    input  logic                 dn_ready,
    output logic [ACC_BITS-1:0]  dn_data,
    output cicd_pkg::ctl_t       dn_ctl
);

    logic                valid_reg;
    logic [ACC_BITS-1:0] dly_reg;
    logic [ACC_BITS-1:0] dly_next;
    logic [ACC_BITS-1:0] diff;
    logic [ACC_BITS-1:0] data_reg;
    cicd_pkg::ctl_t      ctl_reg;
    logic                take;
    logic                apply;

    assign up_ready = !valid_reg || dn_ready;
    assign take     = up_valid && up_ready;
    assign apply    = used && up_ctl.emit;
    assign diff     = up_data - dly_reg;

    always_comb
    begin
        if (up_ctl.last)
            dly_next = '0;
        else if (apply)
            dly_next = up_data;
        else
            dly_next = dly_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            dly_reg   <= '0;
        end
        else
        begin
            if (up_ready)
                valid_reg <= up_valid;
            if (take)
                dly_reg <= dly_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg <= apply ? diff : up_data;
            ctl_reg  <= up_ctl;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;
    assign dn_ctl   = ctl_reg;

endmodule

// ----- sv/cicd_norm.sv -----
// ----------------------------------------------------------------------------
// CIC output normaliser
// Scale by the Q1.32 gain, floor and saturate; four registered stages.
// ----------------------------------------------------------------------------
module cicd_norm #(
    parameter int SAMPLE_BITS = cicd_pkg::SAMPLE_BITS_DEF,
    parameter int ACC_BITS    = cicd_pkg::ACC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [cicd_pkg::SCALE_W-1:0]       scale,
    input  logic                               up_valid,
    output logic                               up_ready,
    input  logic [ACC_BITS-1:0]                up_data,
    input  cicd_pkg::ctl_t                     up_ctl,
    output logic                               dn_valid,
    input  logic                               dn_ready,
    output logic [SAMPLE_BITS-1:0]             dn_sample,
    output logic [ACC_BITS-1:0]                dn_raw
);

    localparam int HI_BITS = (ACC_BITS > 32) ? ACC_BITS - 32 : 1;
    localparam int MAG_W   = 32 + HI_BITS;
    localparam int Q_W     = MAG_W + 2;
    localparam logic [Q_W-1:0] LIM_POS = Q_W'((65'd1 << (SAMPLE_BITS - 1)) - 65'd1);
    localparam logic [Q_W:0]   LIM_NEG = (Q_W + 1)'(65'd1 << (SAMPLE_BITS - 1));

    // Stage 1: sign and magnitude
    logic                v1_reg;
    logic                neg1_reg;
    logic [ACC_BITS-1:0] mag1_reg;
    logic [ACC_BITS-1:0] raw1_reg;
    // Stage 2: partial products
    logic                v2_reg;
    logic                neg2_reg;
    logic                sh2_reg;
    logic [63:0]         lo2_reg;
    logic [MAG_W-1:0]    phi2_reg;
    logic [ACC_BITS-1:0] mag2_reg;
    logic [ACC_BITS-1:0] raw2_reg;
    // Stage 3: floored magnitude
    logic                v3_reg;
    logic                neg3_reg;
    logic                frac3_reg;
    logic [Q_W-1:0]      q3_reg;
    logic [ACC_BITS-1:0] raw3_reg;
    // Output register
    logic                  vo_reg;
    logic [SAMPLE_BITS-1:0] smp_reg;
    logic [ACC_BITS-1:0]    rawo_reg;

    logic rdy2, rdy3, rdy_o;
    logic [MAG_W-1:0]       mag_ext;
    logic [31:0]            ml;
    logic [HI_BITS-1:0]     mh;
    logic [63:0]            lo_next;
    logic [MAG_W-1:0]       phi_next;
    logic [Q_W-1:0]         q_next;
    logic [Q_W:0]           qn;
    logic [Q_W:0]           qn_sat;
    logic [SAMPLE_BITS-1:0] smp_next;

    assign rdy_o    = !vo_reg || dn_ready;
    assign rdy3     = !v3_reg || rdy_o;
    assign rdy2     = !v2_reg || rdy3;
    assign up_ready = !v1_reg || rdy2;

    assign mag_ext  = MAG_W'(mag1_reg);
    assign ml       = mag_ext[31:0];
    assign mh       = mag_ext[MAG_W-1:32];
    assign lo_next  = ml * scale[31:0];
    assign phi_next = mh * scale[31:0];

    assign q_next = Q_W'(phi2_reg) + Q_W'(lo2_reg[63:32])
                  + (sh2_reg ? Q_W'(mag2_reg) : '0);

    // Negative results round towards minus infinity: bump the magnitude
    always_comb
    begin
        qn = {1'b0, q3_reg} + (Q_W + 1)'(frac3_reg);
        qn_sat = (qn > LIM_NEG) ? LIM_NEG : qn;
        if (!neg3_reg)
            smp_next = (q3_reg > LIM_POS) ? LIM_POS[SAMPLE_BITS-1:0]
                                          : q3_reg[SAMPLE_BITS-1:0];
        else
            smp_next = ~qn_sat[SAMPLE_BITS-1:0] + SAMPLE_BITS'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            // Drop samples that give no result at the door
            if (up_ready)
                v1_reg <= up_valid && up_ctl.emit;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
            if (rdy_o)
                vo_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            neg1_reg <= up_data[ACC_BITS-1];
            mag1_reg <= up_data[ACC_BITS-1] ? (~up_data + ACC_BITS'(1)) : up_data;
            raw1_reg <= up_data;
        end
        if (rdy2 && v1_reg)
        begin
            neg2_reg <= neg1_reg;
            sh2_reg  <= scale[32];
            lo2_reg  <= lo_next;
            phi2_reg <= phi_next;
            mag2_reg <= mag1_reg;
            raw2_reg <= raw1_reg;
        end
        if (rdy3 && v2_reg)
        begin
            neg3_reg  <= neg2_reg;
            frac3_reg <= (lo2_reg[31:0] != 32'd0);
            q3_reg    <= q_next;
            raw3_reg  <= raw2_reg;
        end
        if (rdy_o && v3_reg)
        begin
            smp_reg  <= smp_next;
            rawo_reg <= raw3_reg;
        end
    end

    assign dn_valid  = vo_reg;
    assign dn_sample = smp_reg;
    assign dn_raw    = rawo_reg;

endmodule

// ----- sv/cic_decimator_core.sv -----
// ----------------------------------------------------------------------------
// CIC decimator core
// Cascaded integrator-comb decimator built as a chain of pipelined cells.
// ----------------------------------------------------------------------------
// Usage:
//   samples : sink channel, one signed sample per transaction, with block_last
//             marking the final sample of a block.
//   results : source channel, one transaction per decim_ratio samples (the
//             first sample after reset or after a block end always gives one):
//             sample_out is the normalised, saturated sample, raw_out the full
//             comb output.
//   cfg     : register writes (0 decim_ratio, 1 stage count, 2 norm_scale),
//             always ready; write only while no sample is in flight.
// Throughput: one sample per clock while the chain is not stalled. Every
//   integrator and comb stage is a cell with its own register, so a new
//   sample enters each cycle. A sample passes the register of every cell
//   and then the normaliser registers before its result is valid.
// Reset: clears accumulators, comb delays, phase and all valid bits, and
//   loads the register defaults (ratio 10, three stages, scale 1/1000).
// Stall: each stage holds while the next is full; bubbles and samples that
//   give no result keep the chain moving while a result waits to be taken.
// ----------------------------------------------------------------------------
module cic_decimator_core #(
    parameter int MAX_STAGES  = cicd_pkg::MAX_STAGES_DEF,
    parameter int SAMPLE_BITS = cicd_pkg::SAMPLE_BITS_DEF,
    parameter int ACC_BITS    = cicd_pkg::ACC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    cicd_cfg_if.sink    cfg,
    cicd_in_if.sink     samples,
    cicd_out_if.source  results
);

    localparam int NL   = 2 * MAX_STAGES;
    localparam int STW  = cicd_pkg::STAGE_W;
    localparam int RW   = cicd_pkg::RATIO_W;
    localparam int PW   = cicd_pkg::PHASE_W;

    // Configuration registers
    logic [RW-1:0]                  ratio_reg;
    logic [STW-1:0]                 stages_reg;
    logic [cicd_pkg::SCALE_W-1:0]   scale_reg;

    // Decimation phase
    logic [PW-1:0] phase_reg;
    logic [PW-1:0] phase_next;
    logic [RW-1:0] ratio_eff;
    logic [RW-1:0] phase_inc;
    logic          accept;

    // Links between cells: link 0 is the input, link NL feeds the normaliser
    logic                lnk_valid [0:NL];
    logic                lnk_ready [0:NL];
    logic [ACC_BITS-1:0] lnk_data  [0:NL];
    cicd_pkg::ctl_t      lnk_ctl   [0:NL];

    logic [MAX_STAGES-1:0] stage_used;

    // ------------------------------------------------------------------
    // Register writes; always accept
    // ------------------------------------------------------------------
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_reg  <= cicd_pkg::RATIO_RST;
            stages_reg <= cicd_pkg::STAGES_RST;
            scale_reg  <= cicd_pkg::SCALE_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                cicd_pkg::REG_DECIM_RATIO: ratio_reg  <= cfg.data[RW-1:0];
                cicd_pkg::REG_STAGE_CNT:   stages_reg <= cfg.data[STW-1:0];
                cicd_pkg::REG_NORM_SCALE:  scale_reg  <= cfg.data[cicd_pkg::SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage enables: zero stages act as one, the first cell always runs
    // ------------------------------------------------------------------
    for (genvar i = 0; i < MAX_STAGES; i++)
    begin : g_used
        assign stage_used[i] = (i == 0) || (stages_reg > STW'(i));
    end

    // ------------------------------------------------------------------
    // Phase counter: advance on every accepted sample, wrap at the
    // clamped ratio, return to zero after the last sample of a block
    // ------------------------------------------------------------------
    assign accept = samples.valid && samples.ready;

    always_comb
    begin
        if (ratio_reg == '0)
            ratio_eff = RW'(1);
        else if (ratio_reg > cicd_pkg::RATIO_MAX)
            ratio_eff = cicd_pkg::RATIO_MAX;
        else
            ratio_eff = ratio_reg;

        phase_inc = {1'b0, phase_reg} + RW'(1);
        if (samples.block_last || (phase_inc >= ratio_eff))
            phase_next = '0;
        else
            phase_next = phase_inc[PW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= '0;
        else if (accept)
            phase_reg <= phase_next;
    end

    // ------------------------------------------------------------------
    // Chain input: sign-extend the sample, tag it with its control
    // ------------------------------------------------------------------
    assign lnk_valid[0]     = samples.valid;
    assign samples.ready    = lnk_ready[0];
    assign lnk_data[0]      = {{(ACC_BITS - SAMPLE_BITS){samples.sample_in[SAMPLE_BITS-1]}},
                               samples.sample_in};
    assign lnk_ctl[0].emit  = (phase_reg == '0);
    assign lnk_ctl[0].last  = samples.block_last;

    // ------------------------------------------------------------------
    // Integrator cells
    // ------------------------------------------------------------------
    for (genvar k = 0; k < MAX_STAGES; k++)
    begin : g_integ
        cicd_integ_cell #(
            .ACC_BITS (ACC_BITS)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .used     (stage_used[k]),
            .up_valid (lnk_valid[k]),
            .up_ready (lnk_ready[k]),
            .up_data  (lnk_data[k]),
            .up_ctl   (lnk_ctl[k]),
            .dn_valid (lnk_valid[k+1]),
            .dn_ready (lnk_ready[k+1]),
            .dn_data  (lnk_data[k+1]),
            .dn_ctl   (lnk_ctl[k+1])
        );
    end

    // ------------------------------------------------------------------
    // Comb cells: differentiate only decimated samples
    // ------------------------------------------------------------------
    for (genvar k = 0; k < MAX_STAGES; k++)
    begin : g_comb
        cicd_comb_cell #(
            .ACC_BITS (ACC_BITS)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .used     (stage_used[k]),
            .up_valid (lnk_valid[MAX_STAGES+k]),
            .up_ready (lnk_ready[MAX_STAGES+k]),
            .up_data  (lnk_data[MAX_STAGES+k]),
            .up_ctl   (lnk_ctl[MAX_STAGES+k]),
            .dn_valid (lnk_valid[MAX_STAGES+k+1]),
            .dn_ready (lnk_ready[MAX_STAGES+k+1]),
            .dn_data  (lnk_data[MAX_STAGES+k+1]),
            .dn_ctl   (lnk_ctl[MAX_STAGES+k+1])
        );
    end

    // ------------------------------------------------------------------
    // Normaliser and output register; drops samples that give no result
    // ------------------------------------------------------------------
    cicd_norm #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .ACC_BITS    (ACC_BITS)
    ) u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .scale     (scale_reg),
        .up_valid  (lnk_valid[NL]),
        .up_ready  (lnk_ready[NL]),
        .up_data   (lnk_data[NL]),
        .up_ctl    (lnk_ctl[NL]),
        .dn_valid  (results.valid),
        .dn_ready  (results.ready),
        .dn_sample (results.sample_out),
        .dn_raw    (results.raw_out)
    );

endmodule

// ----- sv/cicd_checker.sv -----
// ----------------------------------------------------------------------------
// CIC decimator checker
// Port-level assertions, bound to the core.
// ----------------------------------------------------------------------------
module cicd_checker #(
    parameter int SAMPLE_BITS = cicd_pkg::SAMPLE_BITS_DEF,
    parameter int ACC_BITS    = cicd_pkg::ACC_BITS_DEF
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_ready,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [SAMPLE_BITS-1:0] sample_out,
    input logic [ACC_BITS-1:0]    raw_out
);

    // No result while in reset
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result valid during reset");

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sample_out) && $stable(raw_out))
        else $error("stalled result changed");

    // An empty output means the whole chain can move
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    // Non-negative gain keeps the sign of the raw value
    a_sign_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !raw_out[ACC_BITS-1] |-> !sample_out[SAMPLE_BITS-1])
        else $error("positive raw value gave negative sample");

    a_sign_neg: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && raw_out[ACC_BITS-1] |-> sample_out[SAMPLE_BITS-1] || sample_out == '0)
        else $error("negative raw value gave positive sample");

endmodule

bind cic_decimator_core cicd_checker #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .ACC_BITS    (ACC_BITS)
) u_cicd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (samples.ready),
    .out_valid  (results.valid),
    .out_ready  (results.ready),
    .sample_out (results.sample_out),
    .raw_out    (results.raw_out)
);
